@@ rtl/ioa_pkg.sv @@
package ioa_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COORD_W  = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ioa_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_hold;
    } ioa_stat_t;

endpackage

@@ rtl/ioa_ctrl.sv @@
module ioa_ctrl
    import ioa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ioa_stat_t stat,
    output ioa_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    state_next = CS_SCAN;
                end
            end
            CS_SCAN: begin
                if (stat.scan_done && !stat.out_hold) begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            CS_SCAN: begin
                cmd.step = 1'b1;
                // result goes out only once the output register is free
                cmd.finish = stat.scan_done && !stat.out_hold;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/ioa_datapath.sv @@
module ioa_datapath
    import ioa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COORD_W-1:0]  s_range_start,
    input  logic [COORD_W-1:0]  s_range_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    input  ioa_cmd_t            cmd,
    output ioa_stat_t           stat
);

    logic [2*COORD_W-1:0] mem [CAPACITY];

    logic [COORD_W-1:0]   req_start_reg;
    logic [COORD_W-1:0]   req_end_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 rd_valid_reg;
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 hit_reg;
    logic                 m_valid_reg;
    status_t              status_reg;

    logic                 hit_next;
    logic                 hit_now;
    logic                 overlap;
    logic                 rd_en;
    logic                 wr_en;
    logic [COORD_W-1:0]   ent_start;
    logic [COORD_W-1:0]   ent_end;
    status_t              status_next;

    assign ent_start = rd_data_reg[2*COORD_W-1:COORD_W];
    assign ent_end   = rd_data_reg[COORD_W-1:0];

    // overlaps unless wholly left or wholly right of the stored entry
    assign overlap = !(req_end_reg < ent_start) && !(req_start_reg > ent_end);
    assign hit_now = hit_reg || (rd_valid_reg && overlap);

    assign stat.scan_done = (rd_idx_reg == count_reg);
    assign stat.out_hold  = m_valid_reg && !m_ready;

    assign rd_en = cmd.step && !stat.scan_done;

    always_comb begin
        status_next = ST_GRANTED;
        wr_en       = 1'b0;
        if (hit_now) begin
            status_next = ST_OVERLAP;
        end else if (count_reg == CNT_W'(CAPACITY)) begin
            status_next = ST_FULL;
        end else begin
            wr_en = cmd.finish;
        end
    end

    assign hit_next = cmd.load ? 1'b0 : (cmd.step ? hit_now : hit_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= {req_start_reg, req_end_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_start_reg <= s_range_start;
            req_end_reg   <= s_range_end;
        end
        if (cmd.finish) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            hit_reg <= hit_next;
            if (cmd.load) begin
                rd_idx_reg   <= '0;
                rd_valid_reg <= 1'b0;
            end else begin
                rd_valid_reg <= rd_en;
                if (rd_en) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;

endmodule

@@ rtl/interval_overlap_allocator.sv @@
// interval_overlap_allocator
// input channel s_valid/s_ready carries one request word: s_range_start and
// s_range_end, both inclusive. result channel m_valid/m_ready carries one
// word per request: m_status is 0 granted and stored, 1 refused because it
// overlaps a granted interval, 2 refused because the table is full.
// each request is compared with the granted intervals one per cycle from a
// single-port table of CAPACITY entries with a registered read port.
// the result is registered once the last stored interval has been compared,
// and the block is ready for the next request as the result appears; it
// takes no new request while it is still comparing.
// reset empties the table at once (the entry count goes to zero), drops any
// pending result and makes the block ready for a request.
// the result sits in an output register; a new request is accepted while it
// waits, but that request's result is held back until the receiver has taken
// the previous one, and no further request is taken meanwhile.
module interval_overlap_allocator
    import ioa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COORD_W-1:0]  s_range_start,
    input  logic [COORD_W-1:0]  s_range_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status
);

    ioa_cmd_t  cmd;
    ioa_stat_t stat;

    ioa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ioa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_range_start (s_range_start),
        .s_range_end   (s_range_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

@@ rtl/ioa_checker.sv @@
module ioa_checker
    import ioa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [COORD_W-1:0]  s_range_start,
    input logic [COORD_W-1:0]  s_range_end,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status
);

    // a waiting request word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable(s_range_start) && $stable(s_range_end))
        else $error("request word changed while waiting");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_GRANTED) || (m_status == ST_OVERLAP) ||
                    (m_status == ST_FULL))
        else $error("undefined status code");

    // the block is busy in the cycle after it takes a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken on back-to-back cycles");

    // a fresh result only comes out of a scan: the block was busy just before it appears
    a_result_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a scan");

endmodule

bind interval_overlap_allocator ioa_checker u_ioa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_range_start (s_range_start),
    .s_range_end   (s_range_end),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status)
);
